### sv/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
// No dependencies; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### sv/slfl_pkg.sv
// Package for the sorted list with free list: sizes, codes, microcode table.
// No dependencies; imported by slfl_store and the top level.
`default_nettype none

package slfl_pkg;

  localparam int NODE_COUNT = 16;
  localparam int IDX_W      = $clog2(NODE_COUNT);
  localparam int LINK_W     = $clog2(NODE_COUNT + 1);
  localparam int KEY_W      = 32;

  localparam logic [LINK_W-1:0] NIL = LINK_W'(NODE_COUNT);

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [LINK_W-1:0]       link_t;
  typedef logic signed [KEY_W-1:0] key_t;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_LIST   = 2'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Datapath operation selected by one control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_INS_TAKE,
    OP_WALK,
    OP_INS_LINK,
    OP_INS_SPLICE,
    OP_START,
    OP_DEL_CHECK,
    OP_DEL_UNLINK,
    OP_DEL_FREE,
    OP_LST_EMIT
  } op_t;

  // Branch condition tested by one control word.
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_FREE_NIL,
    C_HEAD_NIL,
    C_LT_GO,
    C_NE_GO,
    C_MISS,
    C_LIST_FIN
  } cond_t;

  typedef logic [3:0] step_t;

  localparam step_t S_INS_TAKE   = 4'd0;
  localparam step_t S_INS_WALK   = 4'd1;
  localparam step_t S_INS_LINK   = 4'd2;
  localparam step_t S_INS_SPLICE = 4'd3;
  localparam step_t S_DEL_START  = 4'd4;
  localparam step_t S_DEL_WALK   = 4'd5;
  localparam step_t S_DEL_CHECK  = 4'd6;
  localparam step_t S_DEL_UNLINK = 4'd7;
  localparam step_t S_DEL_FREE   = 4'd8;
  localparam step_t S_LST_START  = 4'd9;
  localparam step_t S_LST_EMIT   = 4'd10;
  localparam step_t S_END        = 4'd15;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t t_true;
    step_t t_false;
  } uword_t;

  // One write beat into the node store.
  typedef struct packed {
    logic  link_we;
    idx_t  link_idx;
    link_t link_data;
    logic  key_we;
    idx_t  key_idx;
    key_t  key_data;
  } store_wr_t;

  // Control store: one word per step.
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    case (s)
      S_INS_TAKE:   w = '{OP_INS_TAKE,   C_FREE_NIL, S_END,        S_INS_WALK};
      S_INS_WALK:   w = '{OP_WALK,       C_LT_GO,    S_INS_WALK,   S_INS_LINK};
      S_INS_LINK:   w = '{OP_INS_LINK,   C_ALWAYS,   S_INS_SPLICE, S_INS_SPLICE};
      S_INS_SPLICE: w = '{OP_INS_SPLICE, C_ALWAYS,   S_END,        S_END};
      S_DEL_START:  w = '{OP_START,      C_HEAD_NIL, S_END,        S_DEL_WALK};
      S_DEL_WALK:   w = '{OP_WALK,       C_NE_GO,    S_DEL_WALK,   S_DEL_CHECK};
      S_DEL_CHECK:  w = '{OP_DEL_CHECK,  C_MISS,     S_END,        S_DEL_UNLINK};
      S_DEL_UNLINK: w = '{OP_DEL_UNLINK, C_ALWAYS,   S_DEL_FREE,   S_DEL_FREE};
      S_DEL_FREE:   w = '{OP_DEL_FREE,   C_ALWAYS,   S_END,        S_END};
      S_LST_START:  w = '{OP_START,      C_HEAD_NIL, S_END,        S_LST_EMIT};
      S_LST_EMIT:   w = '{OP_LST_EMIT,   C_LIST_FIN, S_END,        S_LST_EMIT};
      default:      w = '{OP_NOP,        C_ALWAYS,   S_END,        S_END};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### sv/slfl_store.sv
// Node store: key and link of every node, one write beat per cycle.
// Depends on slfl_pkg. Links reset to the initial free chain.
`default_nettype none

module slfl_store (
  input  logic               clk,
  input  logic               rst,
  input  slfl_pkg::store_wr_t wr,
  input  slfl_pkg::idx_t      link_raddr,
  input  slfl_pkg::idx_t      key_raddr,
  output slfl_pkg::link_t     link_rdata,
  output slfl_pkg::key_t      key_rdata
);
  import slfl_pkg::*;

  key_t  node_keys  [NODE_COUNT];
  link_t node_links [NODE_COUNT];

  // chain node i to i+1, last one to null
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NODE_COUNT; i++) begin
        node_links[i] <= LINK_W'(i + 1);
      end
    end else if (wr.link_we) begin
      node_links[wr.link_idx] <= wr.link_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.key_we) begin
      node_keys[wr.key_idx] <= wr.key_data;
    end
  end

  assign link_rdata = node_links[link_raddr];
  assign key_rdata  = node_keys[key_raddr];

endmodule

`default_nettype wire

### sv/sorted_list_with_free_list_core.sv
// Sorted list with free list: microcoded walker over a 16-node store.
// The walk loop handles one node per cycle and list emits one beat a cycle. Busy
// drops as the final beat goes out, so the next command can be taken in the cycle
// that carries that beat. Results cannot be stalled.
// Synchronous reset chains all nodes into the free list and empties the list.
`default_nettype none

module sorted_list_with_free_list_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 action,
  input  logic signed [slfl_pkg::KEY_W-1:0] key,
  output logic                       result_valid,
  output logic [1:0]                 status,
  output logic signed [slfl_pkg::KEY_W-1:0] out_key,
  output logic                       last
);
  import slfl_pkg::*;

  `include "assert_macros.svh"

  // Sequencer state
  step_t pc;
  step_t pc_next;
  uword_t uw;
  logic  cond_hit;

  // Datapath registers
  link_t list_head;
  link_t free_head;
  link_t prev;
  link_t pres;
  idx_t  node;
  link_t steps;
  key_t  key_r;

  // Store interface
  store_wr_t wr;
  idx_t      link_raddr;
  link_t     link_rd;
  key_t      key_rd;

  // Derived flags
  logic head_ok;
  logic free_ok;
  logic pres_ok;
  logic prev_ok;
  logic link_ok;
  logic room;
  logic lt_go;
  logic ne_go;
  logic miss;
  logic list_fin;

  // Result beat of this step
  logic    emit;
  status_t emit_status;
  key_t    emit_key;
  logic    emit_last;

  logic accept;

  slfl_store u_store (
    .clk        (clk),
    .rst        (rst),
    .wr         (wr),
    .link_raddr (link_raddr),
    .key_raddr  (pres[IDX_W-1:0]),
    .link_rdata (link_rd),
    .key_rdata  (key_rd)
  );

  assign accept = start && !busy;
  assign uw     = ucode(pc);

  // Read the free head's link while taking a node, else follow the walker.
  assign link_raddr = (uw.op == OP_INS_TAKE) ? free_head[IDX_W-1:0] : pres[IDX_W-1:0];

  assign head_ok  = list_head < NIL;
  assign free_ok  = free_head < NIL;
  assign pres_ok  = pres < NIL;
  assign prev_ok  = prev < NIL;
  assign link_ok  = link_rd < NIL;
  assign room     = steps < NIL;
  assign lt_go    = pres_ok && room && (key_rd < key_r);
  assign ne_go    = pres_ok && room && (key_rd != key_r);
  assign miss     = !pres_ok || (key_rd != key_r);
  // stop on null link or when the step budget runs out
  assign list_fin = !link_ok || (steps == NIL - LINK_W'(1));

  always_comb begin
    case (uw.cond)
      C_ALWAYS:   cond_hit = 1'b1;
      C_FREE_NIL: cond_hit = !free_ok;
      C_HEAD_NIL: cond_hit = !head_ok;
      C_LT_GO:    cond_hit = lt_go;
      C_NE_GO:    cond_hit = ne_go;
      C_MISS:     cond_hit = miss;
      C_LIST_FIN: cond_hit = list_fin;
      default:    cond_hit = 1'b1;
    endcase
    pc_next = cond_hit ? uw.t_true : uw.t_false;
  end

  // Result beat and store writes per operation
  always_comb begin
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_key    = '0;
    emit_last   = 1'b1;
    wr          = '0;
    if (busy) begin
      case (uw.op)
        OP_INS_TAKE: begin
          if (!free_ok) begin
            emit        = 1'b1;
            emit_status = ST_FULL;
          end else begin
            wr.key_we   = 1'b1;
            wr.key_idx  = free_head[IDX_W-1:0];
            wr.key_data = key_r;
          end
        end
        OP_INS_LINK: begin
          wr.link_we   = 1'b1;
          wr.link_idx  = node;
          wr.link_data = pres_ok ? pres : NIL;
        end
        OP_INS_SPLICE: begin
          emit = 1'b1;
          if (prev_ok) begin
            wr.link_we   = 1'b1;
            wr.link_idx  = prev[IDX_W-1:0];
            wr.link_data = {1'b0, node};
          end
        end
        OP_START: begin
          if (!head_ok) begin
            emit        = 1'b1;
            emit_status = ST_EMPTY;
          end
        end
        OP_DEL_CHECK: begin
          if (miss) begin
            emit        = 1'b1;
            emit_status = ST_NOT_FOUND;
          end
        end
        OP_DEL_UNLINK: begin
          if (prev_ok) begin
            wr.link_we   = 1'b1;
            wr.link_idx  = prev[IDX_W-1:0];
            wr.link_data = link_rd;
          end
        end
        OP_DEL_FREE: begin
          emit         = 1'b1;
          wr.link_we   = 1'b1;
          wr.link_idx  = pres[IDX_W-1:0];
          wr.link_data = free_head;
        end
        OP_LST_EMIT: begin
          emit      = 1'b1;
          emit_key  = key_rd;
          emit_last = list_fin;
        end
        default: begin
        end
      endcase
    end
  end

  // Control state: step counter, busy, list and free heads, result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      pc           <= S_END;
      result_valid <= 1'b0;
      list_head    <= NIL;
      free_head    <= '0;
    end else begin
      result_valid <= emit;
      if (accept) begin
        // jump straight to the routine for this command; unused code is dropped
        case (action)
          ACT_INSERT: begin
            busy <= 1'b1;
            pc   <= S_INS_TAKE;
          end
          ACT_DELETE: begin
            busy <= 1'b1;
            pc   <= S_DEL_START;
          end
          ACT_LIST: begin
            busy <= 1'b1;
            pc   <= S_LST_START;
          end
          default: begin
            pc <= S_END;
          end
        endcase
      end else if (busy) begin
        pc <= pc_next;
        if (pc_next == S_END) begin
          busy <= 1'b0;
        end
        case (uw.op)
          OP_INS_TAKE: begin
            if (free_ok) begin
              free_head <= link_ok ? link_rd : NIL;
            end
          end
          OP_INS_SPLICE: begin
            if (!prev_ok) begin
              list_head <= {1'b0, node};
            end
          end
          OP_DEL_UNLINK: begin
            if (!prev_ok) begin
              list_head <= link_rd;
            end
          end
          OP_DEL_FREE: begin
            free_head <= pres;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Walker and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= key;
    end
    if (busy) begin
      case (uw.op)
        OP_INS_TAKE: begin
          node  <= free_head[IDX_W-1:0];
          prev  <= NIL;
          pres  <= head_ok ? list_head : NIL;
          steps <= '0;
        end
        OP_START: begin
          prev  <= NIL;
          pres  <= list_head;
          steps <= '0;
        end
        OP_WALK: begin
          // advance one node while the loop condition holds
          if (cond_hit) begin
            prev  <= pres;
            pres  <= link_rd;
            steps <= steps + LINK_W'(1);
          end
        end
        OP_LST_EMIT: begin
          pres  <= link_rd;
          steps <= steps + LINK_W'(1);
        end
        default: begin
        end
      endcase
    end
    if (emit) begin
      status  <= emit_status;
      out_key <= emit_key;
      last    <= emit_last;
    end
  end

  // A beat only follows a busy cycle.
  `ASSERT_IMPLIES(a_beat_from_busy, clk, rst, result_valid, $past(busy), "beat while idle")
  // Every command that went busy ends with a final beat.
  `ASSERT_IMPLIES(a_end_has_last, clk, rst, $fell(busy), result_valid && last, "no final beat")
  // A node never heads both chains.
  `ASSERT_ALWAYS(a_heads, clk, rst, !head_ok || !free_ok || list_head != free_head, "shared head")

endmodule

`default_nettype wire
